// ----- hdl/pmsm_pkg.sv -----
// Shared constants, payload types and sequencer states of the pattern matcher.
package pmsm_pkg;

	localparam int NUM_SLOTS = 128;
	localparam int MAX_LEN   = 32;
	localparam int BYTE_W    = 8;
	localparam int SLOT_W    = 7;
	localparam int POS_W     = 5;
	localparam int LEN_W     = 6;
	localparam int TAG_W     = 8;
	localparam int ADDR_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int SEEN_W    = $clog2(MAX_LEN + 1);
	localparam int ROW_W     = MAX_LEN * BYTE_W;
	localparam int SHIFT_W   = $clog2(ROW_W);

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_PAT_BYTE = 2'd0;
	localparam opcode_t OP_PAT_HDR  = 2'd1;
	localparam opcode_t OP_TEXT     = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  position;
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0]  pattern_length;
		logic [TAG_W-1:0]  tag;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] match_slot;
		logic [TAG_W-1:0]  match_tag;
	} res_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [TAG_W-1:0] tag;
	} hdr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAG,
		ST_RES
	} state_t;

endpackage

// ----- hdl/pmsm_if.sv -----
// Valid/ready channel interfaces for the command and result streams.
interface pmsm_cmd_if
	import pmsm_pkg::*;
	();
	logic valid;
	logic ready;
	cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pmsm_res_if
	import pmsm_pkg::*;
	();
	logic valid;
	logic ready;
	res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/priority_multi_pattern_substring_match_top.sv -----
// Top level of the priority multi-pattern substring matcher.
//
// The cmd channel carries three kinds of transaction: a pattern byte load, a
// pattern header load (length and tag of a slot) and a text byte. A load is
// written as it is accepted. A text byte shifts into a 32-byte window of the
// newest text and then starts a scan: one shared comparator checks the window
// against one stored pattern per cycle, walking from slot zero upward and
// stopping at the first match. A text byte therefore occupies the block while
// it checks the L slots still worth checking (the smaller of active_patterns
// and the best slot found so far in this text); the comparator and the one-row
// read port of the pattern memory set this pace, and cmd.ready is low for the
// whole scan. On a text byte marked last the block reads the tag of the
// winning slot in ST_TAG, posts one result transaction on the res channel
// from ST_RES, then clears the window, byte count and best slot for the next
// text. The result waits in an output register, so a stalled receiver does
// not hold up new loads or text bytes; only a second result waits for the
// first. Reset clears the window, the counters, the active_patterns register
// and the output valid flag; the pattern memories are not cleared and must be
// loaded before use. The user must write active_patterns through cfg_we and
// cfg_wdata only while idle; the block itself does not enforce this.
module priority_multi_pattern_substring_match_top
	import pmsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pmsm_cmd_if.sink    cmd,
	pmsm_res_if.source  res,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	// Pattern rows: one 32-byte row per slot, written a byte at a time.
	logic [ROW_W-1:0]  pat_mem [NUM_SLOTS];
	// Slot headers: length and tag.
	hdr_t              hdr_mem [NUM_SLOTS];

	state_t            state_q, state_d;
	logic [7:0]        active_q;
	logic [ROW_W-1:0]  win_q;
	logic [SEEN_W-1:0] seen_q;
	logic [CNT_W-1:0]  best_q;
	logic [CNT_W-1:0]  limit_q;
	logic [CNT_W-1:0]  issue_q;
	logic              last_q;
	logic              pend_q;
	logic [ADDR_W-1:0] cmp_slot_s1;
	logic [ROW_W-1:0]  row_s1;
	hdr_t              hdr_s1;
	logic              res_valid_q;
	res_t              res_q;

	logic              accept;
	logic [ADDR_W-1:0] rd_addr;
	logic              issue_en;
	logic              hit;
	logic              res_load;
	logic [CNT_W-1:0]  act_clip;
	logic [CNT_W-1:0]  limit_d;
	logic [LEN_W-1:0]  shift_bytes;
	logic [ROW_W-1:0]  aligned;
	logic [MAX_LEN-1:0] byte_ok;
	logic              len_ok;
	logic              found;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign res.valid = res_valid_q;
	assign res.payload = res_q;

	// Scan bound for a new text byte: active slots, clipped to the table, and
	// never past a slot that already matched earlier in this text.
	always_comb begin
		act_clip = (active_q > 8'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : CNT_W'(active_q);
		limit_d  = (best_q < act_clip) ? best_q : act_clip;
	end

	// Comparator: align the newest len bytes of the window with the pattern row.
	always_comb begin
		shift_bytes = LEN_W'(MAX_LEN) - hdr_s1.len;
		aligned = win_q >> {shift_bytes[SHIFT_W-4:0], 3'b000};
		for (int i = 0; i < MAX_LEN; i++) begin
			byte_ok[i] = (row_s1[i*BYTE_W +: BYTE_W] == aligned[i*BYTE_W +: BYTE_W])
				|| (LEN_W'(i) >= hdr_s1.len);
		end
		len_ok = (hdr_s1.len != '0) && (hdr_s1.len <= LEN_W'(MAX_LEN))
			&& (LEN_W'(seen_q) >= hdr_s1.len);
		hit = (state_q == ST_SCAN) && pend_q && len_ok && (&byte_ok);
	end

	assign found = (best_q < CNT_W'(NUM_SLOTS));

	// Sequencer: next state and per-cycle control.
	always_comb begin
		state_d  = state_q;
		rd_addr  = best_q[ADDR_W-1:0];
		issue_en = 1'b0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd.payload.opcode == OP_TEXT)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_addr  = issue_q[ADDR_W-1:0];
				issue_en = (issue_q < limit_q) && !hit;
				if (hit || (issue_q >= limit_q)) begin
					state_d = last_q ? ST_TAG : ST_IDLE;
				end
			end
			ST_TAG: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				if (!res_valid_q || res.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (accept && (cmd.payload.opcode == OP_PAT_BYTE)
			&& ({1'b0, cmd.payload.slot} < (SLOT_W+1)'(NUM_SLOTS))
			&& ({1'b0, cmd.payload.position} < (POS_W+1)'(MAX_LEN))) begin
			pat_mem[cmd.payload.slot[ADDR_W-1:0]][cmd.payload.position*BYTE_W +: BYTE_W]
				<= cmd.payload.data_byte;
		end
		if (accept && (cmd.payload.opcode == OP_PAT_HDR)
			&& ({1'b0, cmd.payload.slot} < (SLOT_W+1)'(NUM_SLOTS))) begin
			hdr_mem[cmd.payload.slot[ADDR_W-1:0]] <= '{len: cmd.payload.pattern_length,
				tag: cmd.payload.tag};
		end
		row_s1 <= pat_mem[rd_addr];
		hdr_s1 <= hdr_mem[rd_addr];
		cmp_slot_s1 <= rd_addr;
	end

	// Per-text state and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			seen_q  <= '0;
			best_q  <= CNT_W'(NUM_SLOTS);
			limit_q <= '0;
			issue_q <= '0;
			last_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= issue_en;
			if (issue_en) begin
				issue_q <= issue_q + 1'b1;
			end
			if (hit) begin
				best_q <= CNT_W'(cmp_slot_s1);
			end
			if (accept && (cmd.payload.opcode == OP_TEXT)) begin
				win_q   <= {cmd.payload.data_byte, win_q[ROW_W-1:BYTE_W]};
				if (seen_q < SEEN_W'(MAX_LEN)) begin
					seen_q <= seen_q + 1'b1;
				end
				limit_q <= limit_d;
				issue_q <= '0;
				last_q  <= cmd.payload.last;
			end
			if (res_load) begin
				win_q  <= '0;
				seen_q <= '0;
				best_q <= CNT_W'(NUM_SLOTS);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.found      <= found;
			res_q.match_slot <= found ? SLOT_W'(best_q) : '0;
			res_q.match_tag  <= found ? hdr_s1.tag : '0;
		end
	end

`ifndef SYNTHESIS
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= CNT_W'(NUM_SLOTS))
		else $error("best slot register out of range");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_q <= limit_q))
		else $error("scan issued past its limit");

	a_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_W'(MAX_LEN))
		else $error("byte count passed the window size");

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_RES))
		else $error("result posted outside the result state");

	a_hit_improves: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> (best_q < $past(limit_q)))
		else $error("match did not lower the best slot");
`endif

endmodule
